### hw/rtl/hfr_pkg.sv
// Shared constants and the hex character decode for the framed hex receiver.
// Used by every module of the block; no dependencies.
package hfr_pkg;

  // Parameter defaults
  localparam int PAYLOAD_BYTES_DEF = 8;
  localparam int RING_DEPTH_DEF    = 8;

  // Read request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes and reset values
  localparam logic CFG_HEADER = 1'b0;
  localparam logic CFG_FOOTER = 1'b1;
  localparam logic [7:0] HEADER_RST = 8'h02;
  localparam logic [7:0] FOOTER_RST = 8'h03;

  // Input commands
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // ASCII hex decode constants
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] OFS_DIGIT    = 8'h30;
  localparam logic [7:0] OFS_LETTER   = 8'h37;

  // Signed char compare against 'A': values 0x80..0xFF count as below
  function automatic logic [7:0] hex_nibble(input logic [7:0] c);
    logic below;
    below = (c < CHAR_UPPER_A) || c[7];
    return below ? (c - OFS_DIGIT) : (c - OFS_LETTER);
  endfunction

endpackage

### hw/rtl/hfr_ifs.sv
// Valid/ready channel interfaces for the framed hex receiver.
// Input channel carries command and rx_byte; result channel carries one payload byte.
interface hfr_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface hfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  logic       empty_res;

  modport source (output valid, output data_byte, output last, output empty_res, input ready);
  modport sink   (input valid, input data_byte, input last, input empty_res, output ready);
endinterface

### hw/rtl/hfr_front.sv
// Front end: accepts transfers, runs the frame parser, decodes hex pairs into the
// ring slot being filled, owns the ring pointers and queues read requests.
// Depends on hfr_pkg and hfr_ifs.
module hfr_front #(
  parameter int PAYLOAD_BYTES = hfr_pkg::PAYLOAD_BYTES_DEF,
  parameter int RING_DEPTH    = hfr_pkg::RING_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  hfr_in_if.sink in_ch,
  input  logic       cfg_we,
  input  logic       cfg_idx,
  input  logic [7:0] cfg_wdata,
  // read request queue
  input  logic q_full,
  input  logic [hfr_pkg::QUEUE_DEPTH:0] busy_vld,
  input  logic [$clog2(RING_DEPTH+1)-1:0] busy_slot [hfr_pkg::QUEUE_DEPTH+1],
  output logic q_push,
  output logic q_empty_flag,
  output logic [$clog2(RING_DEPTH+1)-1:0] q_slot,
  // ring memory write port
  output logic mem_we,
  output logic [$clog2(RING_DEPTH+1)+((PAYLOAD_BYTES>1)?$clog2(PAYLOAD_BYTES):1)-1:0] mem_addr,
  output logic [7:0] mem_wdata
);

  localparam int S   = RING_DEPTH + 1;            // one spare slot for the frame in progress
  localparam int SW  = $clog2(S);
  localparam int CW  = $clog2(RING_DEPTH + 1);
  localparam int BW  = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int PW  = $clog2(2 * PAYLOAD_BYTES + 1);
  localparam int NB  = hfr_pkg::QUEUE_DEPTH + 1;
  localparam logic [PW-1:0] CHARS     = PW'(2 * PAYLOAD_BYTES);
  localparam logic [SW-1:0] SLOT_LAST = SW'(S - 1);
  localparam logic [CW-1:0] CNT_FULL  = CW'(RING_DEPTH);

  logic [7:0]    hdr_r, ftr_r;
  logic          open_r, open_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [3:0]    hi_r, hi_nxt;
  logic [SW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          hazard, acc, is_hdr, is_ftr;
  logic [7:0]    nib;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + 1'b1;
  endfunction

  // Hold off while the slot being filled is still being read out
  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < NB; k++) begin
      if (busy_vld[k] && (busy_slot[k] == tail_r)) hazard = 1'b1;
    end
  end

  assign in_ch.ready = !q_full && !hazard;
  assign acc    = in_ch.valid && in_ch.ready;
  assign is_hdr = (in_ch.rx_byte == hdr_r);
  assign is_ftr = (in_ch.rx_byte == ftr_r);

  // Read requests: pop the ring now, the back end streams the slot later
  assign q_push       = acc && (in_ch.command == hfr_pkg::CMD_READ);
  assign q_empty_flag = (cnt_r == '0);
  assign q_slot       = head_r;

  // Decoded byte goes straight into the spare slot
  assign nib       = hfr_pkg::hex_nibble(in_ch.rx_byte);
  assign mem_addr  = {tail_r, BW'(pos_r >> 1)};
  assign mem_wdata = {hi_r, 4'h0} + nib;

  // Frame parser and ring pointer update
  always_comb begin
    open_nxt = open_r;
    pos_nxt  = pos_r;
    hi_nxt   = hi_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    mem_we   = 1'b0;
    if (acc && (in_ch.command == hfr_pkg::CMD_BYTE)) begin
      if (is_hdr) begin
        open_nxt = 1'b1;
        pos_nxt  = '0;
      end else if (is_ftr) begin
        if (open_r && (pos_r == CHARS)) begin
          tail_nxt = slot_inc(tail_r);
          if (cnt_r == CNT_FULL) begin
            head_nxt = slot_inc(head_r);   // overwrite the oldest packet
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        open_nxt = 1'b0;
        pos_nxt  = '0;
      end else if (open_r) begin
        if (pos_r == CHARS) begin
          open_nxt = 1'b0;                 // too many characters
          pos_nxt  = '0;
        end else begin
          if (pos_r[0]) begin
            mem_we = 1'b1;
          end else begin
            hi_nxt = nib[3:0];
          end
          pos_nxt = pos_r + 1'b1;
        end
      end
    end else if (q_push && (cnt_r != '0)) begin
      cnt_nxt  = cnt_r - 1'b1;
      head_nxt = slot_inc(head_r);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= hfr_pkg::HEADER_RST;
      ftr_r <= hfr_pkg::FOOTER_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        hfr_pkg::CFG_HEADER: hdr_r <= cfg_wdata;
        hfr_pkg::CFG_FOOTER: ftr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Parser state and ring pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      pos_r  <= '0;
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      open_r <= open_nxt;
      pos_r  <= pos_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // High nibble of the current pair
  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
  end

endmodule

### hw/rtl/hfr_rdq.sv
// Short read request queue between front and back end.
// Exposes its entries so the front can see which ring slots are still pending.
// Depends on hfr_pkg.
module hfr_rdq #(
  parameter int RING_DEPTH = hfr_pkg::RING_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic push_empty,
  input  logic [$clog2(RING_DEPTH+1)-1:0] push_slot,
  input  logic pop,
  output logic full,
  output logic head_vld,
  output logic head_empty,
  output logic [$clog2(RING_DEPTH+1)-1:0] head_slot,
  output logic [hfr_pkg::QUEUE_DEPTH-1:0] ent_busy,
  output logic [$clog2(RING_DEPTH+1)-1:0] ent_slot [hfr_pkg::QUEUE_DEPTH]
);

  localparam int QD  = hfr_pkg::QUEUE_DEPTH;
  localparam int QPW = (QD > 1) ? $clog2(QD) : 1;
  localparam int SW  = $clog2(RING_DEPTH + 1);
  localparam logic [QPW-1:0] PTR_LAST = QPW'(QD - 1);

  logic [QD-1:0]  vld_r;
  logic [QD-1:0]  empty_r;
  logic [SW-1:0]  slot_r [QD];
  logic [QPW-1:0] wr_ptr_r, rd_ptr_r;

  assign full       = &vld_r;
  assign head_vld   = vld_r[rd_ptr_r];
  assign head_empty = empty_r[rd_ptr_r];
  assign head_slot  = slot_r[rd_ptr_r];
  assign ent_busy   = vld_r & ~empty_r;
  assign ent_slot   = slot_r;

  // Pointers and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (pop) begin
        vld_r[rd_ptr_r] <= 1'b0;
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push) begin
        vld_r[wr_ptr_r] <= 1'b1;
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
    end
  end

  // Entry payload
  always_ff @(posedge clk) begin
    if (push) begin
      empty_r[wr_ptr_r] <= push_empty;
      slot_r[wr_ptr_r]  <= push_slot;
    end
  end

endmodule

### hw/rtl/hfr_back.sv
// Back end: holds the packet ring memory, streams a popped slot as payload bytes
// through a registered read and an output register. Depends on hfr_pkg, hfr_ifs.
module hfr_back #(
  parameter int PAYLOAD_BYTES = hfr_pkg::PAYLOAD_BYTES_DEF,
  parameter int RING_DEPTH    = hfr_pkg::RING_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  hfr_out_if.source out_ch,
  // read request queue head
  input  logic q_vld,
  input  logic q_empty,
  input  logic [$clog2(RING_DEPTH+1)-1:0] q_slot,
  output logic q_pop,
  // ring memory write port from the front
  input  logic mem_we,
  input  logic [$clog2(RING_DEPTH+1)+((PAYLOAD_BYTES>1)?$clog2(PAYLOAD_BYTES):1)-1:0] mem_addr,
  input  logic [7:0] mem_wdata,
  // slot currently being streamed
  output logic act_vld,
  output logic [$clog2(RING_DEPTH+1)-1:0] act_slot
);

  localparam int S  = RING_DEPTH + 1;
  localparam int SW = $clog2(S);
  localparam int BW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int AW = SW + BW;
  localparam int MEM_DEPTH = S << BW;
  localparam logic [BW-1:0] LAST_IDX = BW'(PAYLOAD_BYTES - 1);
  localparam logic ONE_BYTE = (PAYLOAD_BYTES == 1);

  typedef enum logic {BK_IDLE, BK_STREAM} bk_state_t;

  bk_state_t     state_r;
  logic [SW-1:0] slot_r;
  logic [BW-1:0] idx_r;
  logic          pend_r, pend_last_r, pend_empty_r;
  logic [7:0]    rd_q_r;
  logic          out_vld_r, out_last_r, out_empty_r;
  logic [7:0]    out_data_r;
  logic [7:0]    mem_r [MEM_DEPTH];

  logic          out_free, load, can_issue, issue_stream, issue_new, rd_en;
  logic [AW-1:0] rd_addr;

  assign out_free     = !out_vld_r || out_ch.ready;
  assign load         = pend_r && out_free;
  assign can_issue    = !pend_r || load;
  assign issue_stream = can_issue && (state_r == BK_STREAM);
  assign issue_new    = can_issue && (state_r == BK_IDLE) && q_vld;
  assign q_pop        = issue_new;
  assign rd_en        = issue_stream || (issue_new && !q_empty);
  assign rd_addr      = issue_stream ? {slot_r, idx_r} : {q_slot, BW'(0)};

  assign act_vld  = (state_r == BK_STREAM);
  assign act_slot = slot_r;

  assign out_ch.valid     = out_vld_r;
  assign out_ch.data_byte = out_data_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.empty_res = out_empty_r;

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem_r[mem_addr] <= mem_wdata;
    if (rd_en) rd_q_r <= mem_r[rd_addr];
  end

  // Sequencer, pending read flags and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end

      if (issue_stream) begin
        pend_r       <= 1'b1;
        pend_last_r  <= (idx_r == LAST_IDX);
        pend_empty_r <= 1'b0;
        idx_r        <= idx_r + 1'b1;
        if (idx_r == LAST_IDX) state_r <= BK_IDLE;
      end else if (issue_new) begin
        pend_r <= 1'b1;
        if (q_empty) begin
          pend_last_r  <= 1'b1;
          pend_empty_r <= 1'b1;
        end else begin
          pend_last_r  <= ONE_BYTE;
          pend_empty_r <= 1'b0;
          slot_r       <= q_slot;
          idx_r        <= BW'(1);
          state_r      <= ONE_BYTE ? BK_IDLE : BK_STREAM;
        end
      end else if (load) begin
        pend_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r  <= pend_empty_r ? 8'h00 : rd_q_r;
      out_last_r  <= pend_last_r;
      out_empty_r <= pend_empty_r;
    end
  end

endmodule

### hw/rtl/hex_frame_receiver_ring_top.sv
// Top level of the framed ASCII-hex packet receiver with packet ring.
// Depends on hfr_pkg, hfr_ifs, hfr_front, hfr_rdq and hfr_back.
//
//  port     | dir | payload                        | transfer when
//  ---------+-----+--------------------------------+---------------------------
//  in_ch    | in  | command, rx_byte               | in_ch.valid && in_ch.ready
//  out_ch   | out | data_byte, last, empty_res     | out_ch.valid && out_ch.ready
//  cfg_*    | in  | cfg_idx, cfg_wdata             | cfg_we
//
// Decoded hex pairs go straight into the ring memory.
// A read yields PAYLOAD_BYTES results (one for an empty ring) at one per cycle while out_ch.ready
// holds; the first passes through the queue entry, the registered ring read and the output register.
// Up to QUEUE_DEPTH reads wait between the front and the streaming back end.
// in_ch stalls while that queue is full or the slot being filled is still read out.
// Reset is synchronous; memories need no clearing pass.
module hex_frame_receiver_ring_top #(
  parameter int PAYLOAD_BYTES = hfr_pkg::PAYLOAD_BYTES_DEF,
  parameter int RING_DEPTH    = hfr_pkg::RING_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  hfr_in_if.sink    in_ch,
  hfr_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic       cfg_idx,
  input  logic [7:0] cfg_wdata
);

  localparam int SW = $clog2(RING_DEPTH + 1);
  localparam int BW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam int AW = SW + BW;
  localparam int QD = hfr_pkg::QUEUE_DEPTH;

  logic          q_push, q_push_empty, q_full, q_vld, q_head_empty, q_pop;
  logic [SW-1:0] q_push_slot, q_head_slot;
  logic [QD-1:0] q_busy;
  logic [SW-1:0] q_ent_slot [QD];
  logic          act_vld;
  logic [SW-1:0] act_slot;
  logic [QD:0]   busy_vld;
  logic [SW-1:0] busy_slot [QD+1];
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  // Slots still owed to the result side: the streaming one and queued ones
  always_comb begin
    busy_vld[0]  = act_vld;
    busy_slot[0] = act_slot;
    for (int k = 0; k < QD; k++) begin
      busy_vld[k+1]  = q_busy[k];
      busy_slot[k+1] = q_ent_slot[k];
    end
  end

  hfr_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .RING_DEPTH    (RING_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_wdata    (cfg_wdata),
    .q_full       (q_full),
    .busy_vld     (busy_vld),
    .busy_slot    (busy_slot),
    .q_push       (q_push),
    .q_empty_flag (q_push_empty),
    .q_slot       (q_push_slot),
    .mem_we       (mem_we),
    .mem_addr     (mem_addr),
    .mem_wdata    (mem_wdata)
  );

  hfr_rdq #(
    .RING_DEPTH (RING_DEPTH)
  ) u_rdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_empty (q_push_empty),
    .push_slot  (q_push_slot),
    .pop        (q_pop),
    .full       (q_full),
    .head_vld   (q_vld),
    .head_empty (q_head_empty),
    .head_slot  (q_head_slot),
    .ent_busy   (q_busy),
    .ent_slot   (q_ent_slot)
  );

  hfr_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES),
    .RING_DEPTH    (RING_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_ch    (out_ch),
    .q_vld     (q_vld),
    .q_empty   (q_head_empty),
    .q_slot    (q_head_slot),
    .q_pop     (q_pop),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .act_vld   (act_vld),
    .act_slot  (act_slot)
  );

  // Never push a read request into a full queue
  a_no_q_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("read request pushed into full queue");

  // A ring write must not hit the slot being streamed out
  a_no_write_on_stream: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && act_vld) |-> (mem_addr[AW-1:BW] != act_slot))
    else $error("ring write into slot under readout");

  // An empty-ring result is always the single, final result of its read
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.empty_res) |-> out_ch.last)
    else $error("empty result without last");

  // Pop from the queue only when it holds a request
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_vld)
    else $error("queue popped while empty");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for hex_frame_receiver_ring_top: drives framed hex bytes and reads,
// predicts every popped packet and compares it field by field.
// Depends on hfr_pkg, the hfr_in_if / hfr_out_if interfaces and the RTL of the block.
module testbench;

  localparam int PB            = hfr_pkg::PAYLOAD_BYTES_DEF;
  localparam int RD            = hfr_pkg::RING_DEPTH_DEF;
  localparam int FRAME_CHARS   = 2 * PB;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 200;

  typedef struct {
    logic [7:0] data_byte;
    logic       last;
    logic       empty_res;
  } readout_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_idx;
  logic [7:0] cfg_wdata;

  hfr_in_if  rx_ch ();
  hfr_out_if pkt_ch ();

  hex_frame_receiver_ring_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (rx_ch),
    .out_ch    (pkt_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted state of the receiver and its packet ring
  logic [7:0] header_val;
  logic [7:0] footer_val;
  bit         frame_is_open;
  int         frame_chars;
  logic [7:0] char_hold [FRAME_CHARS];
  logic [7:0] ring_bytes [RD * PB];
  int         slot_newest;
  int         slot_oldest;
  int         packets_held;

  readout_t expected_bytes[$];
  int       error_count;
  bit       tx_idle;
  bit       rx_idle;
  int       hold_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("hex_frame_receiver_ring_top verification failed");
    $finish;
  end

  task automatic flag_error(input string what);
    $display("MISMATCH: %s", what);
    error_count++;
  endtask

  // Hex character to nibble, signed compare against 'A'
  function automatic logic [7:0] char_value(input logic [7:0] c);
    if ($signed(c) < $signed(8'h41)) return c - 8'h30;
    return c - 8'h37;
  endfunction

  function automatic void clear_model();
    header_val    = hfr_pkg::HEADER_RST;
    footer_val    = hfr_pkg::FOOTER_RST;
    frame_is_open = 1'b0;
    frame_chars   = 0;
    slot_newest   = 0;
    slot_oldest   = 0;
    packets_held  = 0;
    foreach (char_hold[i]) char_hold[i] = '0;
    foreach (ring_bytes[i]) ring_bytes[i] = '0;
  endfunction

  // Decode the completed frame into the ring, overwriting the oldest when full
  function automatic void store_frame();
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] v;
    if (packets_held != 0) slot_newest = (slot_newest + 1) % RD;
    if (packets_held < RD) packets_held++;
    else slot_oldest = (slot_oldest + 1) % RD;
    for (int i = 0; i < PB; i++) begin
      hi = char_value(char_hold[2 * i]);
      lo = char_value(char_hold[2 * i + 1]);
      v  = (hi << 4) + lo;
      ring_bytes[slot_newest * PB + i] = v;
    end
  endfunction

  // Advance the prediction by one accepted transfer
  function automatic void predict_ring_item(input logic cmd, input logic [7:0] b);
    readout_t r;
    if (cmd == hfr_pkg::CMD_BYTE) begin
      if (b == header_val) begin
        frame_is_open = 1'b1;
        frame_chars   = 0;
      end else if (b == footer_val) begin
        if (frame_is_open && frame_chars == FRAME_CHARS) store_frame();
        frame_is_open = 1'b0;
        frame_chars   = 0;
      end else if (frame_is_open) begin
        if (frame_chars >= FRAME_CHARS) begin
          frame_is_open = 1'b0;
          frame_chars   = 0;
        end else begin
          char_hold[frame_chars] = b;
          frame_chars++;
        end
      end
    end else if (packets_held == 0) begin
      r.data_byte = '0;
      r.last      = 1'b1;
      r.empty_res = 1'b1;
      expected_bytes.push_back(r);
    end else begin
      for (int i = 0; i < PB; i++) begin
        r.data_byte = ring_bytes[slot_oldest * PB + i];
        r.last      = (i == PB - 1);
        r.empty_res = 1'b0;
        expected_bytes.push_back(r);
      end
      packets_held--;
      if (packets_held != 0) slot_oldest = (slot_oldest + 1) % RD;
    end
  endfunction

  // One input transfer, with a random lead-in gap
  task automatic send_item(input logic cmd, input logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.command <= cmd;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    predict_ring_item(cmd, b);
  endtask

  task automatic send_read();
    send_item(hfr_pkg::CMD_READ, 8'($urandom_range(0, 255)));
  endtask

  // Frame character: mostly hex digits, sometimes any byte, never a marker
  function automatic logic [7:0] pick_char();
    string      digits;
    logic [7:0] c;
    digits = "0123456789ABCDEFabcdef";
    do begin
      if ($urandom_range(0, 3) != 0) c = digits[$urandom_range(0, 21)];
      else c = 8'($urandom_range(0, 255));
    end while (c == header_val || c == footer_val);
    return c;
  endfunction

  // Header, optional restart, n characters with reads mixed in, footer
  task automatic send_frame(input int n_chars, input bit restart, input int read_pct);
    int k;
    send_item(hfr_pkg::CMD_BYTE, header_val);
    if (restart) begin
      k = $urandom_range(1, 8);
      repeat (k) send_item(hfr_pkg::CMD_BYTE, pick_char());
      send_item(hfr_pkg::CMD_BYTE, header_val);
    end
    for (int i = 0; i < n_chars; i++) begin
      if ($urandom_range(0, 99) < read_pct) send_read();
      send_item(hfr_pkg::CMD_BYTE, pick_char());
    end
    send_item(hfr_pkg::CMD_BYTE, footer_val);
  endtask

  // Stop offering and wait for the block to go quiet
  task automatic settle_block();
    rx_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers, back to back, only while idle
  task automatic write_markers(input logic [7:0] hdr, input logic [7:0] ftr);
    cfg_we    <= 1'b1;
    cfg_idx   <= hfr_pkg::CFG_HEADER;
    cfg_wdata <= hdr;
    @(posedge clk);
    cfg_idx   <= hfr_pkg::CFG_FOOTER;
    cfg_wdata <= ftr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    header_val = hdr;
    footer_val = ftr;
  endtask

  // Mixed well-formed and broken traffic
  task automatic run_traffic(input int n_seq, input int read_pct);
    int pick;
    int n;
    repeat (n_seq) begin
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      pick    = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame(FRAME_CHARS, $urandom_range(0, 4) == 0, read_pct);
      end else if (pick < 72) begin
        send_frame($urandom_range(0, FRAME_CHARS + 4), $urandom_range(0, 3) == 0, read_pct);
      end else if (pick < 82) begin
        n = $urandom_range(1, 3);
        repeat (n) send_item(hfr_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        send_read();
      end
      if ($urandom_range(0, 99) < read_pct) send_read();
    end
  endtask

  // Reset values, idle data, empty read, one frame over the decode corners
  task automatic test_directed_basics();
    logic [7:0] corner [16];
    corner = '{8'h30, 8'h39, 8'h41, 8'h46, 8'h61, 8'h66, 8'h80, 8'hFF,
               8'h7F, 8'h40, 8'h00, 8'h01, 8'h5A, 8'h20, 8'h3F, 8'hC3};
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_item(hfr_pkg::CMD_BYTE, 8'h30);
    send_read();
    send_item(hfr_pkg::CMD_BYTE, hfr_pkg::HEADER_RST);
    foreach (corner[i]) send_item(hfr_pkg::CMD_BYTE, corner[i]);
    send_item(hfr_pkg::CMD_BYTE, hfr_pkg::FOOTER_RST);
    send_read();
    settle_block();
  endtask

  // Two random traffic sequences (clean, short, long or restarted frames, stray bytes, reads) under extreme markers
  task automatic test_frame_errors();
    write_markers(8'h00, 8'hFF);
    run_traffic(2, 10);
    settle_block();
  endtask

  // Overfill the ring, then pop it while the receiver holds off for a long stretch
  task automatic test_ring_overwrite();
    write_markers(8'hFF, 8'h00);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int i = 0; i < RD + 1; i++) begin
      tx_idle = (i % 3 != 0);
      send_frame(FRAME_CHARS, 1'b0, 0);
    end
    settle_block();
    hold_cycles = HOLD_CYCLES;
    tx_idle     = 1'b0;
    repeat (RD + 2) send_read();
    settle_block();
    rx_idle = 1'b0;
  endtask

  // Header and footer equal: the marker always reopens, nothing is stored
  task automatic test_equal_markers();
    write_markers(8'h7E, 8'h7E);
    tx_idle = 1'b1;
    send_frame(FRAME_CHARS, 1'b0, 0);
    send_read();
    settle_block();
  endtask

  task automatic test_random_markers();
    logic [7:0] hdr;
    logic [7:0] ftr;
    hdr = 8'($urandom_range(0, 255));
    do ftr = 8'($urandom_range(0, 255)); while (ftr == hdr);
    write_markers(hdr, ftr);
    run_traffic(1, 25);
    settle_block();
  endtask

  // Result check: oldest expectation against each transfer
  always @(posedge clk) begin
    readout_t want;
    if (rst_n && pkt_ch.valid && pkt_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        flag_error($sformatf("unexpected result data=%02h last=%0b empty=%0b",
                             pkt_ch.data_byte, pkt_ch.last, pkt_ch.empty_res));
      end else begin
        want = expected_bytes.pop_front();
        if (pkt_ch.data_byte !== want.data_byte)
          flag_error($sformatf("data_byte %02h, want %02h", pkt_ch.data_byte, want.data_byte));
        if (pkt_ch.last !== want.last)
          flag_error($sformatf("last %0b, want %0b", pkt_ch.last, want.last));
        if (pkt_ch.empty_res !== want.empty_res)
          flag_error($sformatf("empty_res %0b, want %0b", pkt_ch.empty_res, want.empty_res));
      end
    end
  end

  // Result side ready: random stall per transfer, long hold on request
  initial begin
    int gap;
    pkt_ch.ready <= 1'b0;
    forever begin
      if (hold_cycles != 0) begin
        pkt_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      gap = rx_idle ? $urandom_range(0, 15) : 0;
      if (gap != 0) begin
        pkt_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pkt_ch.ready <= 1'b1;
      do @(posedge clk); while (!pkt_ch.valid);
    end
  end

  // Test sequence
  initial begin
    error_count = 0;
    hold_cycles = 0;
    tx_idle     = 1'b0;
    rx_idle     = 1'b0;
    clear_model();
    rst_n         <= 1'b0;
    rx_ch.valid   <= 1'b0;
    rx_ch.command <= hfr_pkg::CMD_BYTE;
    rx_ch.rx_byte <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= hfr_pkg::CFG_HEADER;
    cfg_wdata     <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_basics();
    test_frame_errors();
    test_ring_overwrite();
    test_equal_markers();
    test_random_markers();

    if (error_count == 0) begin
      $display("hex_frame_receiver_ring_top verification clean");
    end else begin
      $display("hex_frame_receiver_ring_top verification failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/hfr_pkg.sv
hw/rtl/hfr_ifs.sv
hw/rtl/hfr_front.sv
hw/rtl/hfr_rdq.sv
hw/rtl/hfr_back.sv
hw/rtl/hex_frame_receiver_ring_top.sv
tb/testbench.sv
